FILE: design/stream_fault_injector_top_macros.svh
//------------------------------------------------------------------------------
// stream_fault_injector_top_macros
// Assertion helpers shared by the fault injector RTL.
//------------------------------------------------------------------------------
`ifndef STREAM_FAULT_INJECTOR_TOP_MACROS_SVH
`define STREAM_FAULT_INJECTOR_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define SFI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define SFI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/sfi_pkg.sv
//------------------------------------------------------------------------------
// sfi_pkg
// Widths, register codes, reset values and generator constants of the
// stream fault injector.
//------------------------------------------------------------------------------
package sfi_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned MAX_W    = 16;
   localparam int unsigned MODE_W   = 2;
   localparam int unsigned BLOCK_W  = 13;
   localparam int unsigned RNG_W    = 31;
   localparam int unsigned LEN_W    = 29;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned BURST_W  = 6;

   typedef logic [BYTE_W-1:0]    byte_type;
   typedef logic [MAX_W-1:0]     max_type;
   typedef logic [MODE_W-1:0]    mode_type;
   typedef logic [BLOCK_W-1:0]   block_type;
   typedef logic [RNG_W-1:0]     rng_type;
   typedef logic [LEN_W-1:0]     len_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   typedef logic [BURST_W-1:0]   burst_type;

   // register indexes
   localparam csr_idx_type REG_MAX_GAP    = 3'd0;
   localparam csr_idx_type REG_MAX_RUN    = 3'd1;
   localparam csr_idx_type REG_MODE       = 3'd2;
   localparam csr_idx_type REG_FILL_BYTE  = 3'd3;
   localparam csr_idx_type REG_BLOCK_SIZE = 3'd4;
   localparam csr_idx_type REG_RNG_SEED   = 3'd5;

   // corruption modes (code 3 acts as overwrite)
   localparam mode_type MODE_OVERWRITE = 2'd0;
   localparam mode_type MODE_INSERT    = 2'd1;
   localparam mode_type MODE_DELETE    = 2'd2;

   // register reset values
   localparam max_type   MAX_GAP_RST    = 16'd64000;
   localparam max_type   MAX_RUN_RST    = 16'd1024;
   localparam mode_type  MODE_RST       = MODE_OVERWRITE;
   localparam byte_type  FILL_BYTE_RST  = 8'd0;
   localparam block_type BLOCK_SIZE_RST = 13'd1;
   localparam rng_type   RNG_SEED_RST   = 31'd1;

   // 31-bit LCG
   localparam rng_type LCG_MUL  = 31'd1103515245;
   localparam rng_type LCG_INC  = 31'd12345;
   localparam rng_type RNG_FULL = 31'h7FFF_FFFF;

   localparam burst_type MAX_BURST = 6'd63;

endpackage

FILE: design/stream_fault_injector_top.sv
//------------------------------------------------------------------------------
// stream_fault_injector_top
// Byte stream fault injector: random corrupted runs separated by random gaps.
//------------------------------------------------------------------------------
// One item is taken at a time; req_ready is high only while the sequencer is
// idle. Each byte goes through accept, decide, prepare and, unless deleted,
// output. A new length draw adds one LCG step, two 31-step passes of the
// shared restoring divider (0x7FFFFFFF / max, then rng / that quotient) and
// the block_size multiply. The first byte after reset or after a write to
// registers 0 to 5 draws twice (priming plus its own draw when the first gap
// is zero). In insert mode the fill bytes are sent before the byte. Results
// wait in an output register, so a stalled rsp side only holds the block
// once the next result is ready. Register writes are taken at any time
// (csr_ready is tied high) but must only be issued while no item is in flight.
module stream_fault_injector_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sfi_pkg::byte_type      req_data_in,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sfi_pkg::byte_type      rsp_data_out,
   output logic                   rsp_is_fill,
   output logic                   rsp_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  sfi_pkg::csr_idx_type   csr_index,
   input  sfi_pkg::rng_type       csr_data
);
   import sfi_pkg::*;

   `include "stream_fault_injector_top_macros.svh"

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_LCG    = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_LEN    = 3'd4;
   localparam logic [2:0] S_APPLY  = 3'd5;
   localparam logic [2:0] S_PREP   = 3'd6;
   localparam logic [2:0] S_OUT    = 3'd7;

   localparam logic [1:0] KIND_PRIME = 2'd0;
   localparam logic [1:0] KIND_GAP   = 2'd1;
   localparam logic [1:0] KIND_RUN   = 2'd2;

   localparam logic [4:0] DIV_LAST = 5'd30;

   // configuration
   max_type   max_gap_ff, max_gap_in;
   max_type   max_run_ff, max_run_in;
   mode_type  mode_ff, mode_in;
   byte_type  fill_ff, fill_in;
   block_type block_ff, block_in;
   rng_type   seed_ff, seed_in;

   // sequencer and stream state
   logic [2:0] state_ff, state_in;
   logic [1:0] kind_ff, kind_in;
   rng_type    rng_ff, rng_in;
   len_type    gap_ff, gap_in;
   len_type    run_ff, run_in;
   len_type    len_ff, len_in;
   logic       in_run_ff, in_run_in;
   logic       primed_ff, primed_in;
   logic       corrupt_ff, corrupt_in;
   byte_type   data_ff, data_in;
   burst_type  burst_ff, burst_in;

   // shared divider
   rng_type    div_rem_ff, div_rem_in;
   rng_type    div_quo_ff, div_quo_in;
   rng_type    div_dvsr_ff, div_dvsr_in;
   logic [4:0] div_cnt_ff, div_cnt_in;
   logic       div_pass_ff, div_pass_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   byte_type   rsp_data_ff, rsp_data_in;
   logic       rsp_fill_ff, rsp_fill_in;
   logic       rsp_last_ff, rsp_last_in;

   logic [RNG_W:0]   div_shift;
   logic [RNG_W:0]   div_diff;
   logic             div_ge;
   rng_type          div_quo_step;
   rng_type          lcg_next;
   max_type          max_sel;
   rng_type          max_dvsr;
   logic [MAX_W:0]   q_plus;
   logic [LEN_W:0]   len_prod;
   logic             out_free;

   assign req_ready    = (state_ff == S_IDLE);
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_is_fill  = rsp_fill_ff;
   assign rsp_last     = rsp_last_ff;

   // one restoring divide step
   assign div_shift    = {div_rem_ff, div_quo_ff[RNG_W-1]};
   assign div_diff     = div_shift - {1'b0, div_dvsr_ff};
   assign div_ge       = (div_shift >= {1'b0, div_dvsr_ff});
   assign div_quo_step = {div_quo_ff[RNG_W-2:0], div_ge};

   assign lcg_next = rng_ff * LCG_MUL + LCG_INC;

   assign max_sel  = (kind_ff == KIND_RUN) ? max_run_ff : max_gap_ff;
   assign max_dvsr = (max_sel == '0) ? RNG_W'(1) : RNG_W'(max_sel);

   // quotient never exceeds 0xFFFF, so 16 bits hold it
   assign q_plus   = {1'b0, div_quo_ff[MAX_W-1:0]} + (MAX_W+1)'(1);
   assign len_prod = (LEN_W+1)'(block_ff) * (LEN_W+1)'(q_plus);

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      max_gap_in   = max_gap_ff;
      max_run_in   = max_run_ff;
      mode_in      = mode_ff;
      fill_in      = fill_ff;
      block_in     = block_ff;
      seed_in      = seed_ff;
      state_in     = state_ff;
      kind_in      = kind_ff;
      rng_in       = rng_ff;
      gap_in       = gap_ff;
      run_in       = run_ff;
      len_in       = len_ff;
      in_run_in    = in_run_ff;
      primed_in    = primed_ff;
      corrupt_in   = corrupt_ff;
      data_in      = data_ff;
      burst_in     = burst_ff;
      div_rem_in   = div_rem_ff;
      div_quo_in   = div_quo_ff;
      div_dvsr_in  = div_dvsr_ff;
      div_cnt_in   = div_cnt_ff;
      div_pass_in  = div_pass_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_fill_in  = rsp_fill_ff;
      rsp_last_in  = rsp_last_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         primed_in = 1'b0;
         case (csr_index)
            REG_MAX_GAP:    max_gap_in = csr_data[MAX_W-1:0];
            REG_MAX_RUN:    max_run_in = csr_data[MAX_W-1:0];
            REG_MODE:       mode_in    = csr_data[MODE_W-1:0];
            REG_FILL_BYTE:  fill_in    = csr_data[BYTE_W-1:0];
            REG_BLOCK_SIZE: block_in   = csr_data[BLOCK_W-1:0];
            REG_RNG_SEED:   seed_in    = csr_data;
            default:        primed_in  = primed_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               data_in  = req_data_in;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (!primed_ff) begin
               rng_in   = seed_ff;
               kind_in  = KIND_PRIME;
               state_in = S_LCG;
            end else if (gap_ff != '0) begin
               gap_in     = gap_ff - LEN_W'(1);
               corrupt_in = 1'b0;
               state_in   = S_PREP;
            end else if (run_ff != '0) begin
               corrupt_in = 1'b1;
               state_in   = S_PREP;
            end else if (in_run_ff) begin
               kind_in  = KIND_GAP;
               state_in = S_LCG;
            end else begin
               kind_in  = KIND_RUN;
               state_in = S_LCG;
            end
         end
         S_LCG: begin
            rng_in      = lcg_next;
            div_quo_in  = RNG_FULL;
            div_rem_in  = '0;
            div_dvsr_in = max_dvsr;
            div_cnt_in  = '0;
            div_pass_in = 1'b0;
            state_in    = S_DIV;
         end
         S_DIV: begin
            div_rem_in = div_ge ? div_diff[RNG_W-1:0] : div_shift[RNG_W-1:0];
            div_quo_in = div_quo_step;
            div_cnt_in = div_cnt_ff + 5'd1;
            if (div_cnt_ff == DIV_LAST) begin
               if (!div_pass_ff) begin
                  // second pass: rng / (0x7FFFFFFF / max)
                  div_dvsr_in = div_quo_step;
                  div_quo_in  = rng_ff;
                  div_rem_in  = '0;
                  div_cnt_in  = '0;
                  div_pass_in = 1'b1;
               end else begin
                  state_in = S_LEN;
               end
            end
         end
         S_LEN: begin
            len_in   = len_prod[LEN_W-1:0];
            state_in = S_APPLY;
         end
         S_APPLY: begin
            case (kind_ff)
               KIND_PRIME: begin
                  gap_in    = len_ff;
                  run_in    = '0;
                  in_run_in = 1'b0;
                  primed_in = 1'b1;
                  state_in  = S_DECIDE;
               end
               KIND_GAP: begin
                  // the current byte is the first of the new gap
                  gap_in     = (len_ff != '0) ? len_ff - LEN_W'(1) : '0;
                  in_run_in  = 1'b0;
                  corrupt_in = 1'b0;
                  state_in   = S_PREP;
               end
               default: begin
                  run_in     = len_ff;
                  in_run_in  = 1'b1;
                  corrupt_in = 1'b1;
                  state_in   = S_PREP;
               end
            endcase
         end
         S_PREP: begin
            state_in = S_OUT;
            if (mode_ff == MODE_INSERT) begin
               burst_in = (run_ff < LEN_W'(MAX_BURST)) ? run_ff[BURST_W-1:0] : MAX_BURST;
               run_in   = '0;
            end else if (run_ff != '0) begin
               run_in = run_ff - LEN_W'(1);
               if (mode_ff == MODE_DELETE) begin
                  state_in = S_IDLE;   // byte dropped
               end
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (burst_ff != '0) begin
                  rsp_data_in = fill_ff;
                  rsp_fill_in = 1'b1;
                  rsp_last_in = 1'b0;
                  burst_in    = burst_ff - BURST_W'(1);
               end else begin
                  if (corrupt_ff && mode_ff != MODE_INSERT && mode_ff != MODE_DELETE) begin
                     rsp_data_in = fill_ff;
                     rsp_fill_in = 1'b1;
                  end else begin
                     rsp_data_in = data_ff;
                     rsp_fill_in = 1'b0;
                  end
                  rsp_last_in = 1'b1;
                  state_in    = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_gap_ff   <= MAX_GAP_RST;
         max_run_ff   <= MAX_RUN_RST;
         mode_ff      <= MODE_RST;
         fill_ff      <= FILL_BYTE_RST;
         block_ff     <= BLOCK_SIZE_RST;
         seed_ff      <= RNG_SEED_RST;
         state_ff     <= S_IDLE;
         rng_ff       <= '0;
         gap_ff       <= '0;
         run_ff       <= '0;
         in_run_ff    <= 1'b0;
         primed_ff    <= 1'b0;
         burst_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_gap_ff   <= max_gap_in;
         max_run_ff   <= max_run_in;
         mode_ff      <= mode_in;
         fill_ff      <= fill_in;
         block_ff     <= block_in;
         seed_ff      <= seed_in;
         state_ff     <= state_in;
         rng_ff       <= rng_in;
         gap_ff       <= gap_in;
         run_ff       <= run_in;
         in_run_ff    <= in_run_in;
         primed_ff    <= primed_in;
         burst_ff     <= burst_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      len_ff      <= len_in;
      corrupt_ff  <= corrupt_in;
      data_ff     <= data_in;
      div_rem_ff  <= div_rem_in;
      div_quo_ff  <= div_quo_in;
      div_dvsr_ff <= div_dvsr_in;
      div_cnt_ff  <= div_cnt_in;
      div_pass_ff <= div_pass_in;
      rsp_data_ff <= rsp_data_in;
      rsp_fill_ff <= rsp_fill_in;
      rsp_last_ff <= rsp_last_in;
   end

   `SFI_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready,
      state_ff != S_IDLE, "sequencer idle right after an accepted item")
   `SFI_ASSERT_NOW(a_burst_only_in_output, clock, reset, burst_ff != '0,
      state_ff == S_OUT, "pending fill burst outside the output state")
   `SFI_ASSERT_NOW(a_divisor_nonzero, clock, reset, state_ff == S_DIV,
      div_dvsr_ff != '0, "shared divider running with a zero divisor")

endmodule
